// ===== rtl/bimp_pkg.sv =====
// ----------------------------------------------------------------------------
// bimp_pkg
// Shared types and constants of the boot information memory-map parser:
// tag and region codes, parse phases, command queue entries and result items.
// ----------------------------------------------------------------------------
package bimp_pkg;

   // Tag and region type codes
   localparam logic [31:0] TAG_TYPE_END   = 32'd0;
   localparam logic [31:0] TAG_TYPE_MMAP  = 32'd6;
   localparam logic [31:0] KIND_AVAILABLE = 32'd1;

   // Layout of the block
   localparam logic [31:0] MIN_ENTRY_BYTES = 32'd20;
   localparam logic [32:0] MIN_TAG_BYTES   = 33'd8;
   localparam logic [33:0] TAG_ALIGN_MASK  = 34'd7;
   localparam logic [33:0] MAP_HEADER_BYTES = 34'd16;
   localparam logic [33:0] WORD_BYTES      = 34'd4;

   // Internal count width (holds up to 127 regions)
   localparam int COUNT_W = 7;

   // Command queue depth
   localparam int CMD_DEPTH = 4;
   localparam int CMD_PTR_W = $clog2(CMD_DEPTH);
   localparam int CMD_CNT_W = $clog2(CMD_DEPTH + 1);

   typedef enum logic [3:0] {
      PH_IDLE,
      PH_RSVD,
      PH_TTYPE,
      PH_TSIZE,
      PH_SKIP,
      PH_ESIZE,
      PH_EVER,
      PH_ENTRY,
      PH_DONE
   } phase_type;

   typedef enum logic [2:0] {
      ST_RUNNING  = 3'd0,
      ST_MAP_DONE = 3'd1,
      ST_END_TAG  = 3'd2,
      ST_PAST_END = 3'd3,
      ST_BAD_SIZE = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      CMD_CLEAR,
      CMD_WORD,
      CMD_FINISH
   } cmd_op_type;

   typedef enum logic [2:0] {
      SLOT_NONE,
      SLOT_BASE_LO,
      SLOT_BASE_HI,
      SLOT_LEN_LO,
      SLOT_LEN_HI,
      SLOT_KIND
   } slot_type;

   // One classified word on its way to the back end
   typedef struct packed {
      cmd_op_type           op;
      logic [31:0]          word;
      slot_type             slot;
      logic                 emit;
      logic                 done;
      status_type           status;
      logic                 found;
      logic [COUNT_W-1:0]   count;
   } cmd_type;

   // One result item
   typedef struct packed {
      logic        has_region;
      logic [4:0]  region_index;
      logic [63:0] region_base;
      logic [63:0] region_length;
      logic [31:0] region_kind;
      logic        is_available;
      logic        parse_done;
      logic        map_found;
      logic [5:0]  region_count;
      logic [63:0] available_total;
      logic [2:0]  end_status;
   } rsp_type;

endpackage

// ===== rtl/boot_info_memory_map_parser.sv =====
// ----------------------------------------------------------------------------
// boot_info_memory_map_parser
// Memory-map parser for a boot information block streamed as 32-bit words.
//
// Input channel (req_): one little-endian word per transaction; frame_start
// marks the total-size word and restarts parsing. Result channel (rsp_): one
// transaction per completed map entry and one at the end of parsing; an entry
// that ends the parse carries both in a single transaction.
// Throughput: one input word per cycle while the command queue has room,
// set by the walker which does one word of tag bookkeeping per cycle.
// A result passes through the command queue and then the output register
// before rsp_valid rises.
// A four-entry command queue sits between the walker and the result stage;
// req_ready drops only when that queue is full. While the receiver stalls,
// the output register holds one result and every queued command waits
// behind it, entry words that cause no result included; input stalls for
// any word once four commands are queued.
// Reset: synchronous; the walker returns to waiting for a block start, the
// queue empties and no result is pending. No clearing pass is needed.
// ----------------------------------------------------------------------------
module boot_info_memory_map_parser #(
   parameter int MAX_REGIONS = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [31:0] req_data_word,
   input  logic        req_frame_start,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_has_region,
   output logic [4:0]  rsp_region_index,
   output logic [63:0] rsp_region_base,
   output logic [63:0] rsp_region_length,
   output logic [31:0] rsp_region_kind,
   output logic        rsp_is_available,
   output logic        rsp_parse_done,
   output logic        rsp_map_found,
   output logic [5:0]  rsp_region_count,
   output logic [63:0] rsp_available_total,
   output logic [2:0]  rsp_end_status
);

   logic              push;
   logic              queue_full;
   logic              pop;
   logic              queue_not_empty;
   bimp_pkg::cmd_type front_cmd;
   bimp_pkg::cmd_type head_cmd;
   bimp_pkg::rsp_type rsp;

   // Walk tags and classify words
   bimp_front #(
      .MAX_REGIONS(MAX_REGIONS)
   ) u_front (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data_word  (req_data_word),
      .req_frame_start(req_frame_start),
      .queue_full     (queue_full),
      .push           (push),
      .cmd            (front_cmd)
   );

   // Decouple walker from result stage
   bimp_cmd_fifo u_cmd_fifo (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (front_cmd),
      .full     (queue_full),
      .pop      (pop),
      .not_empty(queue_not_empty),
      .head_cmd (head_cmd)
   );

   // Assemble entries and drive results
   bimp_back u_back (
      .clock    (clock),
      .reset    (reset),
      .cmd_valid(queue_not_empty),
      .cmd      (head_cmd),
      .pop      (pop),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp      (rsp)
   );

   assign rsp_has_region      = rsp.has_region;
   assign rsp_region_index    = rsp.region_index;
   assign rsp_region_base     = rsp.region_base;
   assign rsp_region_length   = rsp.region_length;
   assign rsp_region_kind     = rsp.region_kind;
   assign rsp_is_available    = rsp.is_available;
   assign rsp_parse_done      = rsp.parse_done;
   assign rsp_map_found       = rsp.map_found;
   assign rsp_region_count    = rsp.region_count;
   assign rsp_available_total = rsp.available_total;
   assign rsp_end_status      = rsp.end_status;

endmodule

// ===== rtl/bimp_front.sv =====
// ----------------------------------------------------------------------------
// bimp_front
// Accepts block words, walks the tag chain and turns the words that matter
// into commands for the back end: clear, entry word, or finish with a status.
// ----------------------------------------------------------------------------
module bimp_front #(
   parameter int MAX_REGIONS = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [31:0]       req_data_word,
   input  logic              req_frame_start,
   input  logic              queue_full,
   output logic              push,
   output bimp_pkg::cmd_type cmd
);

   localparam logic [bimp_pkg::COUNT_W-1:0] MAX_CNT = bimp_pkg::COUNT_W'(MAX_REGIONS);

   bimp_pkg::phase_type phase_ff, phase_in;
   logic [33:0] byte_off_ff, byte_off_in;
   logic [31:0] block_size_ff, block_size_in;
   logic [31:0] tag_begin_ff, tag_begin_in;
   logic [31:0] tag_len_ff, tag_len_in;
   logic        tag_is_map_ff, tag_is_map_in;
   logic [31:0] entry_bytes_ff, entry_bytes_in;
   logic [31:0] entry_off_ff, entry_off_in;
   logic [33:0] end_ff, end_in;
   logic [bimp_pkg::COUNT_W-1:0] count_ff, count_in;
   logic        found_ff, found_in;

   logic        accept;
   logic [32:0] tag_adv;
   logic [33:0] tag_padded;
   logic [33:0] next_tag;
   logic        past_size;
   logic        short_tag;
   logic [33:0] skip_off;
   logic        skip_done;
   logic        bad_size;
   logic [33:0] first_end;
   logic        first_fits;
   logic [31:0] entry_off_nx;
   logic        entry_last;
   logic [bimp_pkg::COUNT_W-1:0] count_nx;
   logic [33:0] next_end;
   logic        next_fits;
   bimp_pkg::slot_type slot;

   assign req_ready = !queue_full;
   assign accept    = req_valid && req_ready;

   // Tag advance, padded to 8 bytes without wrap
   assign short_tag  = {1'b0, req_data_word} < bimp_pkg::MIN_TAG_BYTES;
   assign tag_adv    = short_tag ? bimp_pkg::MIN_TAG_BYTES : {1'b0, req_data_word};
   assign tag_padded = ({1'b0, tag_adv} + bimp_pkg::TAG_ALIGN_MASK) & ~bimp_pkg::TAG_ALIGN_MASK;
   assign next_tag   = {2'b00, tag_begin_ff} + tag_padded;
   assign past_size  = next_tag >= {2'b00, block_size_ff};

   // Skip words up to the next tag
   assign skip_off  = byte_off_ff + bimp_pkg::WORD_BYTES;
   assign skip_done = skip_off >= {2'b00, tag_begin_ff};

   // Entry size and fit checks
   assign bad_size   = (req_data_word < bimp_pkg::MIN_ENTRY_BYTES) ||
                       (req_data_word[1:0] != 2'b00);
   assign first_end  = bimp_pkg::MAP_HEADER_BYTES + {2'b00, entry_bytes_ff};
   assign first_fits = (count_ff < MAX_CNT) && (first_end <= {2'b00, tag_len_ff});
   assign entry_off_nx = entry_off_ff + 32'd4;
   assign entry_last   = entry_off_nx == entry_bytes_ff;
   assign count_nx     = count_ff + bimp_pkg::COUNT_W'(1);
   assign next_end     = end_ff + {2'b00, entry_bytes_ff};
   assign next_fits    = (count_nx < MAX_CNT) && (next_end <= {2'b00, tag_len_ff});

   // Place of the word inside an entry
   always_comb begin
      slot = bimp_pkg::SLOT_NONE;
      if (entry_off_ff[31:5] == 27'd0) begin
         unique case (entry_off_ff[4:0])
            5'd0:    slot = bimp_pkg::SLOT_BASE_LO;
            5'd4:    slot = bimp_pkg::SLOT_BASE_HI;
            5'd8:    slot = bimp_pkg::SLOT_LEN_LO;
            5'd12:   slot = bimp_pkg::SLOT_LEN_HI;
            5'd16:   slot = bimp_pkg::SLOT_KIND;
            default: slot = bimp_pkg::SLOT_NONE;
         endcase
      end
   end

   // Next parse phase
   always_comb begin
      phase_in = phase_ff;
      if (accept) begin
         if (req_frame_start) begin
            phase_in = bimp_pkg::PH_RSVD;
         end else begin
            unique case (phase_ff)
               bimp_pkg::PH_RSVD:  phase_in = bimp_pkg::PH_TTYPE;
               bimp_pkg::PH_TTYPE: begin
                  phase_in = (req_data_word == bimp_pkg::TAG_TYPE_END) ?
                             bimp_pkg::PH_DONE : bimp_pkg::PH_TSIZE;
               end
               bimp_pkg::PH_TSIZE: begin
                  if (tag_is_map_ff) begin
                     phase_in = bimp_pkg::PH_ESIZE;
                  end else if (past_size) begin
                     phase_in = bimp_pkg::PH_DONE;
                  end else if (tag_padded == {1'b0, bimp_pkg::MIN_TAG_BYTES}) begin
                     phase_in = bimp_pkg::PH_TTYPE;
                  end else begin
                     phase_in = bimp_pkg::PH_SKIP;
                  end
               end
               bimp_pkg::PH_SKIP: begin
                  if (skip_done) begin
                     phase_in = bimp_pkg::PH_TTYPE;
                  end
               end
               bimp_pkg::PH_ESIZE: begin
                  phase_in = bad_size ? bimp_pkg::PH_DONE : bimp_pkg::PH_EVER;
               end
               bimp_pkg::PH_EVER: begin
                  phase_in = first_fits ? bimp_pkg::PH_ENTRY : bimp_pkg::PH_DONE;
               end
               bimp_pkg::PH_ENTRY: begin
                  if (entry_last && !next_fits) begin
                     phase_in = bimp_pkg::PH_DONE;
                  end
               end
               default: phase_in = phase_ff;
            endcase
         end
      end
   end

   // Walker datapath
   always_comb begin
      byte_off_in    = byte_off_ff;
      block_size_in  = block_size_ff;
      tag_begin_in   = tag_begin_ff;
      tag_len_in     = tag_len_ff;
      tag_is_map_in  = tag_is_map_ff;
      entry_bytes_in = entry_bytes_ff;
      entry_off_in   = entry_off_ff;
      end_in         = end_ff;
      count_in       = count_ff;
      found_in       = found_ff;
      if (accept) begin
         if (req_frame_start) begin
            block_size_in = req_data_word;
            byte_off_in   = bimp_pkg::WORD_BYTES;
            count_in      = '0;
            found_in      = 1'b0;
         end else begin
            unique case (phase_ff)
               bimp_pkg::PH_RSVD: begin
                  byte_off_in  = skip_off;
                  tag_begin_in = 32'd8;
               end
               bimp_pkg::PH_TTYPE: begin
                  byte_off_in   = skip_off;
                  tag_is_map_in = req_data_word == bimp_pkg::TAG_TYPE_MMAP;
               end
               bimp_pkg::PH_TSIZE: begin
                  byte_off_in = skip_off;
                  tag_len_in  = req_data_word;
                  if (tag_is_map_ff) begin
                     found_in = 1'b1;
                  end else if (!past_size) begin
                     tag_begin_in = next_tag[31:0];
                  end
               end
               bimp_pkg::PH_SKIP:  byte_off_in = skip_off;
               bimp_pkg::PH_ESIZE: entry_bytes_in = req_data_word;
               bimp_pkg::PH_EVER: begin
                  entry_off_in = '0;
                  end_in       = first_end;
               end
               bimp_pkg::PH_ENTRY: begin
                  if (entry_last) begin
                     entry_off_in = '0;
                     count_in     = count_nx;
                     end_in       = next_end;
                  end else begin
                     entry_off_in = entry_off_nx;
                  end
               end
               default: byte_off_in = byte_off_ff;
            endcase
         end
      end
   end

   // Command to the back end
   always_comb begin
      push       = 1'b0;
      cmd.op     = bimp_pkg::CMD_WORD;
      cmd.word   = req_data_word;
      cmd.slot   = bimp_pkg::SLOT_NONE;
      cmd.emit   = 1'b0;
      cmd.done   = 1'b0;
      cmd.status = bimp_pkg::ST_RUNNING;
      cmd.found  = found_ff;
      cmd.count  = count_ff;
      if (accept) begin
         if (req_frame_start) begin
            push   = 1'b1;
            cmd.op = bimp_pkg::CMD_CLEAR;
         end else begin
            unique case (phase_ff)
               bimp_pkg::PH_TTYPE: begin
                  if (req_data_word == bimp_pkg::TAG_TYPE_END) begin
                     push       = 1'b1;
                     cmd.op     = bimp_pkg::CMD_FINISH;
                     cmd.done   = 1'b1;
                     cmd.status = bimp_pkg::ST_END_TAG;
                  end
               end
               bimp_pkg::PH_TSIZE: begin
                  if (!tag_is_map_ff && past_size) begin
                     push       = 1'b1;
                     cmd.op     = bimp_pkg::CMD_FINISH;
                     cmd.done   = 1'b1;
                     cmd.status = bimp_pkg::ST_PAST_END;
                  end
               end
               bimp_pkg::PH_ESIZE: begin
                  if (bad_size) begin
                     push       = 1'b1;
                     cmd.op     = bimp_pkg::CMD_FINISH;
                     cmd.done   = 1'b1;
                     cmd.status = bimp_pkg::ST_BAD_SIZE;
                  end
               end
               bimp_pkg::PH_EVER: begin
                  if (!first_fits) begin
                     push       = 1'b1;
                     cmd.op     = bimp_pkg::CMD_FINISH;
                     cmd.done   = 1'b1;
                     cmd.status = bimp_pkg::ST_MAP_DONE;
                  end
               end
               bimp_pkg::PH_ENTRY: begin
                  push     = 1'b1;
                  cmd.op   = bimp_pkg::CMD_WORD;
                  cmd.slot = slot;
                  cmd.emit = entry_last;
                  cmd.count = entry_last ? count_nx : count_ff;
                  if (entry_last && !next_fits) begin
                     cmd.done   = 1'b1;
                     cmd.status = bimp_pkg::ST_MAP_DONE;
                  end
               end
               default: push = 1'b0;
            endcase
         end
      end
   end

   // Walker registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= bimp_pkg::PH_IDLE;
         count_ff <= '0;
         found_ff <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         found_ff <= found_in;
      end
   end

   always_ff @(posedge clock) begin
      byte_off_ff    <= byte_off_in;
      block_size_ff  <= block_size_in;
      tag_begin_ff   <= tag_begin_in;
      tag_len_ff     <= tag_len_in;
      tag_is_map_ff  <= tag_is_map_in;
      entry_bytes_ff <= entry_bytes_in;
      entry_off_ff   <= entry_off_in;
      end_ff         <= end_in;
   end

endmodule

// ===== rtl/bimp_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// bimp_cmd_fifo
// Short command queue between the front walker and the back end, so that
// each side can stall on its own.
// ----------------------------------------------------------------------------
module bimp_cmd_fifo (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  bimp_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output logic              not_empty,
   output bimp_pkg::cmd_type head_cmd
);

   bimp_pkg::cmd_type slots_ff [bimp_pkg::CMD_DEPTH];
   logic [bimp_pkg::CMD_PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [bimp_pkg::CMD_PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [bimp_pkg::CMD_CNT_W-1:0] cnt_ff, cnt_in;

   assign full      = cnt_ff == bimp_pkg::CMD_CNT_W'(bimp_pkg::CMD_DEPTH);
   assign not_empty = cnt_ff != '0;
   assign head_cmd  = slots_ff[rd_ptr_ff];

   // Advance pointers and occupancy
   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + bimp_pkg::CMD_PTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + bimp_pkg::CMD_PTR_W'(1) : rd_ptr_ff;
      cnt_in    = cnt_ff;
      if (push && !pop) begin
         cnt_in = cnt_ff + bimp_pkg::CMD_CNT_W'(1);
      end else if (pop && !push) begin
         cnt_in = cnt_ff - bimp_pkg::CMD_CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   // Store the incoming command
   always_ff @(posedge clock) begin
      if (push) begin
         slots_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule

// ===== rtl/bimp_back.sv =====
// ----------------------------------------------------------------------------
// bimp_back
// Carries out queued commands: assembles entry fields, keeps the available
// total, and holds the result item in an output register.
// ----------------------------------------------------------------------------
module bimp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  bimp_pkg::cmd_type cmd,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output bimp_pkg::rsp_type rsp
);

   logic [63:0] base_ff, base_in;
   logic [63:0] len_ff, len_in;
   logic [31:0] kind_ff, kind_in;
   logic [63:0] total_ff, total_in;
   logic        rsp_valid_ff, rsp_valid_in;
   bimp_pkg::rsp_type rsp_ff, rsp_in;

   logic [31:0] kind_now;
   logic        avail_now;
   logic [63:0] total_add;
   logic        has_result;

   assign pop       = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   assign kind_now  = (cmd.slot == bimp_pkg::SLOT_KIND) ? cmd.word : kind_ff;
   assign avail_now = kind_now == bimp_pkg::KIND_AVAILABLE;
   assign total_add = total_ff + (avail_now ? len_ff : 64'd0);

   assign has_result = pop && ((cmd.op == bimp_pkg::CMD_FINISH) ||
                               ((cmd.op == bimp_pkg::CMD_WORD) && cmd.emit));

   // Execute the head command
   always_comb begin
      base_in  = base_ff;
      len_in   = len_ff;
      kind_in  = kind_ff;
      total_in = total_ff;
      if (pop) begin
         unique case (cmd.op)
            bimp_pkg::CMD_CLEAR: total_in = '0;
            bimp_pkg::CMD_WORD: begin
               unique case (cmd.slot)
                  bimp_pkg::SLOT_BASE_LO: base_in[31:0]  = cmd.word;
                  bimp_pkg::SLOT_BASE_HI: base_in[63:32] = cmd.word;
                  bimp_pkg::SLOT_LEN_LO:  len_in[31:0]   = cmd.word;
                  bimp_pkg::SLOT_LEN_HI:  len_in[63:32]  = cmd.word;
                  bimp_pkg::SLOT_KIND:    kind_in        = cmd.word;
                  default:                kind_in        = kind_ff;
               endcase
               if (cmd.emit) begin
                  total_in = total_add;
               end
            end
            default: total_in = total_ff;
         endcase
      end
   end

   // Build the result item
   always_comb begin
      rsp_in.has_region      = 1'b0;
      rsp_in.region_index    = '0;
      rsp_in.region_base     = '0;
      rsp_in.region_length   = '0;
      rsp_in.region_kind     = '0;
      rsp_in.is_available    = 1'b0;
      rsp_in.parse_done      = cmd.done;
      rsp_in.map_found       = cmd.found;
      rsp_in.region_count    = cmd.count[5:0];
      rsp_in.available_total = total_ff;
      rsp_in.end_status      = cmd.status;
      if (cmd.op == bimp_pkg::CMD_WORD) begin
         rsp_in.has_region      = 1'b1;
         rsp_in.region_index    = 5'(cmd.count - bimp_pkg::COUNT_W'(1));
         rsp_in.region_base     = base_ff;
         rsp_in.region_length   = len_ff;
         rsp_in.region_kind     = kind_now;
         rsp_in.is_available    = avail_now;
         rsp_in.available_total = total_add;
      end
   end

   // Hold the result until taken
   always_comb begin
      if (has_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         total_ff     <= '0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         total_ff     <= total_in;
      end
   end

   always_ff @(posedge clock) begin
      base_ff <= base_in;
      len_ff  <= len_in;
      kind_ff <= kind_in;
      if (has_result) begin
         rsp_ff <= rsp_in;
      end
   end

   // Checks on command execution
   a_pop_needs_cmd: assert property (@(posedge clock) disable iff (reset)
      pop |-> cmd_valid)
      else $error("command taken from an empty queue");

   a_clear_zeroes_total: assert property (@(posedge clock) disable iff (reset)
      (pop && (cmd.op == bimp_pkg::CMD_CLEAR)) |=> (total_ff == 64'd0))
      else $error("available total not cleared at block start");

   a_done_has_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.parse_done) |->
      (rsp_ff.end_status != bimp_pkg::ST_RUNNING))
      else $error("finished result without end status");

   a_running_has_region: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ff.parse_done) |->
      (rsp_ff.has_region && (rsp_ff.end_status == bimp_pkg::ST_RUNNING)))
      else $error("running result without a region");

endmodule

// ===== tb/boot_info_memory_map_parser_test.sv =====
// ----------------------------------------------------------------------------
// boot_info_memory_map_parser_test
// Self-checking bench for the boot information memory-map parser. A short
// scripted stream covers the end tag, a bad entry size, a tag past the total
// size, a short tag and an all-ones map entry. Random blocks follow: mostly
// well-formed tag lists with a memory map, plus truncated, corrupted and stray
// words. Each accepted word steps a local parser model, and each result
// transaction is compared field by field against the oldest awaited record.
// ----------------------------------------------------------------------------
module boot_info_memory_map_parser_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int REGION_LIMIT   = 32;
   localparam int SCRIPT_ROWS    = 27;
   localparam int RANDOM_WORDS   = 420;
   localparam int HOLD_CYCLES    = 120;
   localparam int WATCHDOG_LIMIT = 1000;

   // One scripted word; typed rows carry their result written out by hand
   typedef struct packed {
      logic [31:0]          word;
      logic                 start;
      logic                 typed;
      logic                 yields;
      bimp_pkg::status_type status;
      logic                 found;
   } script_row_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_data_word;
   logic        req_frame_start;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_has_region;
   logic [4:0]  rsp_region_index;
   logic [63:0] rsp_region_base;
   logic [63:0] rsp_region_length;
   logic [31:0] rsp_region_kind;
   logic        rsp_is_available;
   logic        rsp_parse_done;
   logic        rsp_map_found;
   logic [5:0]  rsp_region_count;
   logic [63:0] rsp_available_total;
   logic [2:0]  rsp_end_status;

   // Parser model state
   bimp_pkg::phase_type walk_phase = bimp_pkg::PH_IDLE;
   logic [63:0] byte_pos     = '0;
   logic [31:0] frame_bytes  = '0;
   logic [63:0] tag_start    = '0;
   logic [31:0] tag_bytes    = '0;
   logic [31:0] tag_code     = '0;
   logic [31:0] entry_stride = '0;
   logic [31:0] entry_pos    = '0;
   logic [63:0] acc_base     = '0;
   logic [63:0] acc_len      = '0;
   logic [31:0] acc_kind     = '0;
   logic [6:0]  region_tally = '0;
   logic [63:0] avail_sum    = '0;
   logic        map_seen     = 1'b0;

   bimp_pkg::rsp_type awaited_records [$];
   script_row_type    script [0:SCRIPT_ROWS-1];

   int fault_count  = 0;
   int sent_words   = 0;
   int regions_seen = 0;
   int ends_seen    = 0;
   int block_count  = 0;
   int quiet_cycles = 0;
   int status_tally [8];
   int sender_mode  = 0;
   bit hold_ask     = 1'b0;

   boot_info_memory_map_parser #(
      .MAX_REGIONS(REGION_LIMIT)
   ) dut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_data_word      (req_data_word),
      .req_frame_start    (req_frame_start),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_has_region     (rsp_has_region),
      .rsp_region_index   (rsp_region_index),
      .rsp_region_base    (rsp_region_base),
      .rsp_region_length  (rsp_region_length),
      .rsp_region_kind    (rsp_region_kind),
      .rsp_is_available   (rsp_is_available),
      .rsp_parse_done     (rsp_parse_done),
      .rsp_map_found      (rsp_map_found),
      .rsp_region_count   (rsp_region_count),
      .rsp_available_total(rsp_available_total),
      .rsp_end_status     (rsp_end_status)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Does one more entry of the current size fit inside the map tag?
   function automatic bit entry_room();
      logic [63:0] rel;
      rel = byte_pos - tag_start;
      return region_tally < REGION_LIMIT &&
             rel + {32'd0, entry_stride} <= {32'd0, tag_bytes};
   endfunction

   // Fill the summary fields; close the parse when done is set
   function automatic bit report(inout bimp_pkg::rsp_type r, input logic done,
                                 input bimp_pkg::status_type st);
      if (done) walk_phase = bimp_pkg::PH_DONE;
      r.parse_done      = done;
      r.map_found       = map_seen;
      r.region_count    = region_tally[5:0];
      r.available_total = avail_sum;
      r.end_status      = st;
      return 1'b1;
   endfunction

   // Advance the parser model by one word; return 1 when a result is due
   function automatic bit walk_word(input logic [31:0] w, input logic fs,
                                    output bimp_pkg::rsp_type r);
      logic [63:0] adv;
      logic [63:0] nxt;
      r = '0;
      if (fs) begin
         frame_bytes  = w;
         byte_pos     = 64'd4;
         region_tally = '0;
         avail_sum    = '0;
         map_seen     = 1'b0;
         walk_phase   = bimp_pkg::PH_RSVD;
         return 1'b0;
      end
      case (walk_phase)
         bimp_pkg::PH_RSVD: begin
            byte_pos   += 4;
            tag_start  = 64'd8;
            walk_phase = bimp_pkg::PH_TTYPE;
         end
         bimp_pkg::PH_TTYPE: begin
            byte_pos += 4;
            tag_code = w;
            if (w == bimp_pkg::TAG_TYPE_END) return report(r, 1'b1, bimp_pkg::ST_END_TAG);
            walk_phase = bimp_pkg::PH_TSIZE;
         end
         bimp_pkg::PH_TSIZE: begin
            byte_pos  += 4;
            tag_bytes = w;
            if (tag_code == bimp_pkg::TAG_TYPE_MMAP) begin
               map_seen   = 1'b1;
               walk_phase = bimp_pkg::PH_ESIZE;
               return 1'b0;
            end
            // pad without wrap so a huge size lands past the block
            adv = (w < 32'd8) ? 64'd8 : {32'd0, w};
            nxt = tag_start + ((adv + 64'd7) & ~64'd7);
            if (nxt >= {32'd0, frame_bytes}) return report(r, 1'b1, bimp_pkg::ST_PAST_END);
            tag_start  = nxt;
            walk_phase = (byte_pos == nxt) ? bimp_pkg::PH_TTYPE : bimp_pkg::PH_SKIP;
         end
         bimp_pkg::PH_SKIP: begin
            byte_pos += 4;
            if (byte_pos >= tag_start) walk_phase = bimp_pkg::PH_TTYPE;
         end
         bimp_pkg::PH_ESIZE: begin
            byte_pos     += 4;
            entry_stride = w;
            if (w < 32'd20 || w[1:0] != 2'b00) return report(r, 1'b1, bimp_pkg::ST_BAD_SIZE);
            walk_phase = bimp_pkg::PH_EVER;
         end
         bimp_pkg::PH_EVER: begin
            byte_pos += 4;
            if (!entry_room()) return report(r, 1'b1, bimp_pkg::ST_MAP_DONE);
            entry_pos  = '0;
            acc_base   = '0;
            acc_len    = '0;
            acc_kind   = '0;
            walk_phase = bimp_pkg::PH_ENTRY;
         end
         bimp_pkg::PH_ENTRY: begin
            case (entry_pos)
               32'd0:  acc_base[31:0]  = w;
               32'd4:  acc_base[63:32] = w;
               32'd8:  acc_len[31:0]   = w;
               32'd12: acc_len[63:32]  = w;
               32'd16: acc_kind        = w;
               default: ;
            endcase
            entry_pos += 4;
            byte_pos  += 4;
            if (entry_pos != entry_stride) return 1'b0;
            r.has_region    = 1'b1;
            r.region_index  = region_tally[4:0];
            r.region_base   = acc_base;
            r.region_length = acc_len;
            r.region_kind   = acc_kind;
            r.is_available  = (acc_kind == bimp_pkg::KIND_AVAILABLE);
            if (acc_kind == bimp_pkg::KIND_AVAILABLE) avail_sum += acc_len;
            region_tally++;
            entry_pos = '0;
            acc_base  = '0;
            acc_len   = '0;
            acc_kind  = '0;
            if (!entry_room()) return report(r, 1'b1, bimp_pkg::ST_MAP_DONE);
            return report(r, 1'b0, bimp_pkg::ST_RUNNING);
         end
         default: ;
      endcase
      return 1'b0;
   endfunction

   // Offer one word, wait for its transaction, and record what it should cause
   task automatic send_word(input logic [31:0] w, input logic fs, input logic typed,
                            input logic typed_has, input bimp_pkg::rsp_type typed_rsp);
      int                gap;
      bit                due;
      bimp_pkg::rsp_type predicted;
      case (sender_mode)
         0: gap = 0;
         1: gap = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3) : 0;
         default: begin
            gap = 0;
            if ($urandom_range(0, 2) == 0)
               gap = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 30) : $urandom_range(1, 2);
         end
      endcase
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_data_word   <= w;
      req_frame_start <= fs;
      do @(negedge clock); while (!req_ready);
      // the transaction happens at the coming edge
      sent_words++;
      due = walk_word(w, fs, predicted);
      if (typed) begin
         if (typed_has) awaited_records.push_back(typed_rsp);
      end else if (due) begin
         awaited_records.push_back(predicted);
      end
      @(posedge clock);
   endtask

   task automatic send_plain(input logic [31:0] w, input logic fs);
      send_word(w, fs, 1'b0, 1'b0, '0);
   endtask

   // Build one random block and stream it; giant maps run past the region limit
   task automatic send_block(input bit giant);
      logic [31:0] body [$];
      logic [31:0] tag_len;
      logic [31:0] kind;
      logic [31:0] total;
      int          pre_tags, padded, entries, esz, map_len, roll, cut;
      bit          esz_ok;
      body = {};
      sender_mode = $urandom_range(0, 2);
      // drop in a few stray words now and then
      if ($urandom_range(0, 19) == 0)
         repeat ($urandom_range(1, 3)) send_plain($urandom, 1'b0);
      body.push_back($urandom);
      pre_tags = giant ? 0 : $urandom_range(0, 3);
      for (int t = 0; t < pre_tags; t++) begin
         roll = $urandom_range(0, 19);
         kind = (roll == 0) ? 32'hFFFF_FFFF :
                (roll < 10) ? $urandom_range(1, 5) : $urandom_range(7, 40);
         roll = $urandom_range(0, 19);
         tag_len = (roll == 0) ? $urandom_range(0, 7) :
                   (roll == 1) ? $urandom_range(32'hFFFF_FFF8, 32'hFFFF_FFFF) :
                   $urandom_range(8, 48);
         body.push_back(kind);
         body.push_back(tag_len);
         if (roll != 1) begin
            padded = (tag_len < 8) ? 8 : ((tag_len + 7) & ~7);
            for (int b = 8; b < padded; b += 4) body.push_back($urandom);
         end
      end
      if (giant || $urandom_range(0, 19) < 17) begin
         roll = $urandom_range(0, 19);
         esz = giant ? 20 : (roll < 11) ? 24 : (roll < 15) ? 20 :
               (roll < 18) ? 4 * $urandom_range(7, 10) : -1;
         esz_ok = (esz > 0);
         if (!esz_ok)
            esz = $urandom_range(0, 1) ? $urandom_range(0, 19) :
                  4 * $urandom_range(5, 12) + $urandom_range(1, 3);
         entries = giant ? 34 : $urandom_range(0, 5);
         map_len = 16 + entries * esz;
         // short, partial and clipped map tags
         roll = $urandom_range(0, 19);
         if (roll == 0) map_len = $urandom_range(0, 15);
         else if (roll < 3) map_len += $urandom_range(1, 19);
         else if (roll < 5 && entries > 0) map_len -= $urandom_range(1, 20);
         body.push_back(bimp_pkg::TAG_TYPE_MMAP);
         body.push_back(map_len);
         body.push_back(esz);
         body.push_back($urandom);
         if (esz_ok) begin
            for (int e = 0; e < entries; e++) begin
               roll = $urandom_range(0, 19);
               kind = (roll < 10) ? bimp_pkg::KIND_AVAILABLE :
                      (roll < 17) ? $urandom_range(2, 5) : $urandom;
               body.push_back($urandom);
               body.push_back($urandom);
               body.push_back($urandom);
               body.push_back($urandom);
               body.push_back(kind);
               for (int b = 20; b < esz; b += 4) body.push_back($urandom);
            end
         end else begin
            repeat ($urandom_range(1, 4)) body.push_back($urandom);
         end
      end
      body.push_back(bimp_pkg::TAG_TYPE_END);
      body.push_back(32'd8);
      total = 4 * (body.size() + 1);
      roll = $urandom_range(0, 19);
      if (roll == 0) total = 32'hFFFF_FFFF;
      else if (roll < 3) total = $urandom_range(8, total);
      else if (roll == 3) total = $urandom_range(0, 7);
      // truncate or corrupt a few blocks
      cut = body.size();
      if ($urandom_range(0, 9) == 0) cut = $urandom_range(0, body.size());
      if ($urandom_range(0, 19) == 0) body[$urandom_range(0, body.size() - 1)] = $urandom;
      send_plain(total, 1'b1);
      for (int i = 0; i < cut; i++) send_plain(body[i], 1'b0);
      block_count++;
   endtask

   task automatic check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
         fault_count++;
      end
   endtask

   // Compare each result transaction against the oldest awaited record
   always @(negedge clock) begin
      bimp_pkg::rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (awaited_records.size() == 0) begin
            $display("%0t: result with none awaited, region %0d status %0d",
                     $time, rsp_has_region, rsp_end_status);
            fault_count++;
         end else begin
            want = awaited_records.pop_front();
            check_field("has_region", 64'(want.has_region), 64'(rsp_has_region));
            check_field("region_index", 64'(want.region_index), 64'(rsp_region_index));
            check_field("region_base", want.region_base, rsp_region_base);
            check_field("region_length", want.region_length, rsp_region_length);
            check_field("region_kind", 64'(want.region_kind), 64'(rsp_region_kind));
            check_field("is_available", 64'(want.is_available), 64'(rsp_is_available));
            check_field("parse_done", 64'(want.parse_done), 64'(rsp_parse_done));
            check_field("map_found", 64'(want.map_found), 64'(rsp_map_found));
            check_field("region_count", 64'(want.region_count), 64'(rsp_region_count));
            check_field("available_total", want.available_total, rsp_available_total);
            check_field("end_status", 64'(want.end_status), 64'(rsp_end_status));
         end
         if (rsp_has_region) regions_seen++;
         if (rsp_parse_done) begin
            ends_seen++;
            status_tally[rsp_end_status]++;
         end
      end
   end

   // Abort when no transaction moves for too long
   always @(negedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t: timeout, no transaction for %0d cycles, %0d results awaited",
                     $time, quiet_cycles, awaited_records.size());
            $display("[boot_info_memory_map_parser] ERROR");
            $finish;
         end
      end
   end

   // Receiver: free runs, short and long stalls, and one long hold on request
   initial begin : rsp_side
      int stretch;
      rsp_ready = 1'b0;
      @(posedge clock);
      forever begin
         if (hold_ask) begin
            hold_ask = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ready <= 1'b1;
            repeat ($urandom_range(1, 40)) @(posedge clock);
            stretch = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
            if ($urandom_range(0, 3) != 0) begin
               rsp_ready <= 1'b0;
               repeat (stretch) @(posedge clock);
            end
         end
      end
   end

   initial begin : req_side
      bimp_pkg::rsp_type typed_rsp;
      int                first_random;
      reset           = 1'b1;
      req_valid       = 1'b0;
      req_data_word   = '0;
      req_frame_start = 1'b0;
      foreach (status_tally[i]) status_tally[i] = 0;
      script = '{
         // stray word after reset: ignored
         '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         // end tag right away
         '{32'd16, 1'b1, 1'b1, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'd0, 1'b0, 1'b1, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{bimp_pkg::TAG_TYPE_END, 1'b0, 1'b1, 1'b1, bimp_pkg::ST_END_TAG, 1'b0},
         // map with an entry size below the minimum
         '{32'hFFFF_FFFF, 1'b1, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{bimp_pkg::TAG_TYPE_MMAP, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'd40, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'd19, 1'b0, 1'b1, 1'b1, bimp_pkg::ST_BAD_SIZE, 1'b1},
         // small block, huge first tag runs past the total size
         '{32'd8, 1'b1, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'd0, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'd3, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'hFFFF_FFFF, 1'b0, 1'b1, 1'b1, bimp_pkg::ST_PAST_END, 1'b0},
         // short tag, then a map holding one all-ones available entry
         '{32'd200, 1'b1, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'd0, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'd5, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'd4, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{bimp_pkg::TAG_TYPE_MMAP, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'd36, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{bimp_pkg::MIN_ENTRY_BYTES, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'd0, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{32'hFFFF_FFFF, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         '{bimp_pkg::KIND_AVAILABLE, 1'b0, 1'b0, 1'b0, bimp_pkg::ST_RUNNING, 1'b0},
         // word after the parse has finished: ignored
         '{32'd0, 1'b0, 1'b1, 1'b0, bimp_pkg::ST_RUNNING, 1'b0}
      };

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Walk the script
      for (int i = 0; i < SCRIPT_ROWS; i++) begin
         typed_rsp            = '0;
         typed_rsp.parse_done = 1'b1;
         typed_rsp.map_found  = script[i].found;
         typed_rsp.end_status = script[i].status;
         send_word(script[i].word, script[i].start, script[i].typed,
                   script[i].yields, typed_rsp);
      end

      // Random blocks until enough words have gone through
      first_random = sent_words;
      while (sent_words - first_random < RANDOM_WORDS) begin
         // hold the receiver while a long map streams in
         if (block_count == 4) hold_ask = 1'b1;
         send_block(block_count == 4 || $urandom_range(0, 49) == 0);
         // pause the sender until every awaited result is back
         if (block_count == 2) begin
            req_valid <= 1'b0;
            do @(posedge clock); while (awaited_records.size() != 0);
         end
      end

      // Drain and allow for late, unexpected results
      req_valid <= 1'b0;
      do @(posedge clock); while (awaited_records.size() != 0);
      repeat (8) @(posedge clock);

      $display("Streamed %0d random blocks, %0d words; %0d regions, %0d parse ends",
               block_count, sent_words, regions_seen, ends_seen);
      $display("End codes: map %0d, end tag %0d, past size %0d, bad entry %0d",
               status_tally[bimp_pkg::ST_MAP_DONE], status_tally[bimp_pkg::ST_END_TAG],
               status_tally[bimp_pkg::ST_PAST_END], status_tally[bimp_pkg::ST_BAD_SIZE]);
      if (fault_count == 0 && awaited_records.size() == 0) begin
         $display("[boot_info_memory_map_parser] OK");
      end else begin
         $display("[boot_info_memory_map_parser] ERROR");
      end
      $finish;
   end

endmodule
